[hw/rtl/lrp_pkg.sv]
// Shared types, widths and codes of the LR shift-reduce parser unit.
package lrp_pkg;

    // Fixed field widths of the transaction ports.
    localparam int OPCODE_W = 2;
    localparam int STATE_W  = 5;
    localparam int COLUMN_W = 4;
    localparam int MODE_W   = 2;
    localparam int LEN_W    = 3;
    localparam int PROD_W   = 5;
    localparam int KIND_W   = 3;

    // Default table and stack sizes.
    localparam int DEF_NUM_STATES       = 32;
    localparam int DEF_NUM_TERMINALS    = 16;
    localparam int DEF_NUM_NONTERMINALS = 16;
    localparam int DEF_STACK_DEPTH      = 64;
    localparam int DEF_MAX_REDUCTIONS   = 16;

    // Input operations.
    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD_ACTION = 2'd0,
        OP_LOAD_GOTO   = 2'd1,
        OP_TOKEN       = 2'd2,
        OP_RESTART     = 2'd3
    } t_opcode;

    // Modes of an ACTION entry.
    typedef enum logic [MODE_W-1:0] {
        MODE_ERROR  = 2'd0,
        MODE_SHIFT  = 2'd1,
        MODE_REDUCE = 2'd2,
        MODE_ACCEPT = 2'd3
    } t_act_mode;

    // Result kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD   = 3'd0,
        KIND_REDUCE = 3'd1,
        KIND_SHIFT  = 3'd2,
        KIND_ACCEPT = 3'd3,
        KIND_ERROR  = 3'd4
    } t_kind;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_POP,
        ST_GOTO
    } t_ctrl_state;

    // One ACTION table entry.
    typedef struct packed {
        t_act_mode           mode;
        logic [STATE_W-1:0]  next;
        logic [LEN_W-1:0]    len;
        logic [COLUMN_W-1:0] lhs;
        logic [PROD_W-1:0]   prod;
    } t_act_entry;

    // One GOTO table entry.
    typedef struct packed {
        logic               valid;
        logic [STATE_W-1:0] target;
    } t_goto_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic load_action;
        logic load_goto;
        logic restart;
        logic token_start;
        logic fail;
        logic shift;
        logic accept;
        logic reduce_start;
        logic goto_read;
        logic reduce_finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic      clear_last;
        logic      col_ok;
        t_act_mode mode;
        logic      shift_ok;
        logic      reduce_ok;
        logic      goto_ok;
    } t_status;

endpackage

[hw/rtl/lrp_ctrl.sv]
// Controller state machine of the LR shift-reduce parser unit.
module lrp_ctrl import lrp_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  t_status             i_status,
    output t_cmd                o_cmd,
    output logic                o_busy
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    // State register; reset starts the GOTO table clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    unique case (t_opcode'(i_opcode))
                        OP_LOAD_ACTION: o_cmd.load_action = 1'b1;
                        OP_LOAD_GOTO:   o_cmd.load_goto   = 1'b1;
                        OP_RESTART:     o_cmd.restart     = 1'b1;
                        OP_TOKEN: begin
                            if (i_status.col_ok) begin
                                o_cmd.token_start = 1'b1;
                                n_state           = ST_DECODE;
                            end else begin
                                o_cmd.fail = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_DECODE: begin
                n_state = ST_IDLE;
                unique case (i_status.mode)
                    MODE_SHIFT: begin
                        if (i_status.shift_ok) begin
                            o_cmd.shift = 1'b1;
                        end else begin
                            o_cmd.fail = 1'b1;
                        end
                    end
                    MODE_REDUCE: begin
                        if (i_status.reduce_ok) begin
                            o_cmd.reduce_start = 1'b1;
                            n_state            = ST_POP;
                        end else begin
                            o_cmd.fail = 1'b1;
                        end
                    end
                    MODE_ACCEPT: o_cmd.accept = 1'b1;
                    MODE_ERROR:  o_cmd.fail   = 1'b1;
                endcase
            end
            ST_POP: begin
                o_cmd.goto_read = 1'b1;
                n_state         = ST_GOTO;
            end
            ST_GOTO: begin
                if (i_status.goto_ok) begin
                    o_cmd.reduce_finish = 1'b1;
                    n_state             = ST_DECODE;
                end else begin
                    o_cmd.fail = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

[hw/rtl/lrp_dpath.sv]
// Datapath of the LR shift-reduce parser unit: tables, state stack and result register.
module lrp_dpath import lrp_pkg::*; #(
    parameter int NUM_STATES       = DEF_NUM_STATES,
    parameter int NUM_TERMINALS    = DEF_NUM_TERMINALS,
    parameter int NUM_NONTERMINALS = DEF_NUM_NONTERMINALS,
    parameter int STACK_DEPTH      = DEF_STACK_DEPTH,
    parameter int MAX_REDUCTIONS   = DEF_MAX_REDUCTIONS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  logic [STATE_W-1:0]  i_state_index,
    input  logic [COLUMN_W-1:0] i_column,
    input  logic [MODE_W-1:0]   i_entry_mode,
    input  logic [STATE_W-1:0]  i_entry_state,
    input  logic [LEN_W-1:0]    i_rhs_length,
    input  logic [COLUMN_W-1:0] i_lhs_symbol,
    input  logic [PROD_W-1:0]   i_production_number,
    output logic                o_strobe,
    output logic [KIND_W-1:0]   o_kind,
    output logic [PROD_W-1:0]   o_production,
    output logic [STATE_W-1:0]  o_state_now,
    output logic                o_last
);

    localparam int ActDepth = NUM_STATES * NUM_TERMINALS;
    localparam int ActAw    = $clog2(ActDepth);
    localparam int GtDepth  = NUM_STATES * NUM_NONTERMINALS;
    localparam int GtAw     = $clog2(GtDepth);
    localparam int SpW      = $clog2(STACK_DEPTH);
    localparam int RcW      = $clog2(MAX_REDUCTIONS + 1);

    // Table and stack memories.
    t_act_entry         r_act_mem   [ActDepth];
    t_goto_entry        r_goto_mem  [GtDepth];
    logic [STATE_W-1:0] r_stack_mem [STACK_DEPTH];

    // Parser state.
    logic [SpW-1:0]      r_sp;
    logic [STATE_W-1:0]  r_top;
    logic [COLUMN_W-1:0] r_col;
    logic [RcW-1:0]      r_red_cnt;
    logic [GtAw-1:0]     r_clr_addr;

    // Registered memory read data and reduce bookkeeping.
    t_act_entry         r_act;
    t_goto_entry        r_goto_q;
    logic [STATE_W-1:0] r_stack_q;
    logic [SpW-1:0]     r_base;
    logic               r_base_zero;

    // Result register and its next value.
    logic               r_strobe;
    t_kind              r_kind;
    logic [PROD_W-1:0]  r_prod;
    logic [STATE_W-1:0] r_state_now;
    logic               r_last;
    t_kind              n_kind;
    logic [PROD_W-1:0]  n_prod;
    logic [STATE_W-1:0] n_state_now;
    logic               n_last;

    logic [ActAw-1:0]   w_act_wr_addr;
    logic [ActAw-1:0]   w_act_rd_addr;
    logic [GtAw-1:0]    w_goto_wr_addr;
    logic [GtAw-1:0]    w_goto_rd_addr;
    logic [SpW-1:0]     w_base;
    logic [STATE_W-1:0] w_base_state;
    logic               w_row_ok;
    logic               w_len_ok;
    t_act_entry         w_act_wdata;

    // Address arithmetic for loads and lookups.
    assign w_row_ok      = int'(i_state_index) < NUM_STATES;
    assign w_act_wr_addr = ActAw'(int'(i_state_index) * NUM_TERMINALS + int'(i_column));
    assign w_goto_wr_addr = GtAw'(int'(i_state_index) * NUM_NONTERMINALS + int'(i_column));
    assign w_act_rd_addr = i_cmd.token_start
        ? ActAw'(int'(r_top) * NUM_TERMINALS + int'(i_column))
        : ActAw'(int'(r_goto_q.target) * NUM_TERMINALS + int'(r_col));
    assign w_base_state   = r_base_zero ? '0 : r_stack_q;
    assign w_goto_rd_addr = GtAw'(int'(w_base_state) * NUM_NONTERMINALS + int'(r_act.lhs));

    // Pop arithmetic for a reduce entry.
    assign w_len_ok = int'(r_act.len) <= int'(r_sp);
    assign w_base   = r_sp - SpW'(r_act.len);

    assign w_act_wdata = '{
        mode: t_act_mode'(i_entry_mode),
        next: i_entry_state,
        len:  i_rhs_length,
        lhs:  i_lhs_symbol,
        prod: i_production_number
    };

    // Status for the controller.
    always_comb begin
        o_status.clear_last = (r_clr_addr == GtAw'(GtDepth - 1));
        o_status.col_ok     = int'(i_column) < NUM_TERMINALS;
        o_status.mode       = r_act.mode;
        o_status.shift_ok   = (int'(r_act.next) < NUM_STATES)
                              && (r_sp != SpW'(STACK_DEPTH - 1));
        o_status.reduce_ok  = (int'(r_red_cnt) < MAX_REDUCTIONS) && w_len_ok
                              && (int'(r_act.lhs) < NUM_NONTERMINALS);
        o_status.goto_ok    = r_goto_q.valid && (int'(r_goto_q.target) < NUM_STATES)
                              && (r_base != SpW'(STACK_DEPTH - 1));
    end

    // ACTION table: one write port for loads, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_action && w_row_ok && (int'(i_column) < NUM_TERMINALS)) begin
            r_act_mem[w_act_wr_addr] <= w_act_wdata;
        end
        if (i_cmd.token_start || i_cmd.reduce_finish) begin
            r_act <= r_act_mem[w_act_rd_addr];
        end
    end

    // GOTO table: clearing pass and loads share the write port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            r_goto_mem[r_clr_addr] <= '0;
        end else if (i_cmd.load_goto && w_row_ok
                     && (int'(i_column) < NUM_NONTERMINALS)) begin
            r_goto_mem[w_goto_wr_addr] <= '{valid: (i_entry_mode != '0),
                                             target: i_entry_state};
        end
        if (i_cmd.goto_read) begin
            r_goto_q <= r_goto_mem[w_goto_rd_addr];
        end
    end

    // State stack memory; the bottom entry is never written, and state 0 stands in for it when it is read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_stack_mem[r_sp + SpW'(1)] <= r_act.next;
        end else if (i_cmd.reduce_finish) begin
            r_stack_mem[r_base + SpW'(1)] <= r_goto_q.target;
        end
        if (i_cmd.reduce_start) begin
            r_stack_q   <= r_stack_mem[w_base];
            r_base      <= w_base;
            r_base_zero <= (w_base == '0);
        end
    end

    // Clear address counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_addr <= r_clr_addr + GtAw'(1);
        end
    end

    // Stack pointer, top-of-stack copy and reduction count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp      <= '0;
            r_top     <= '0;
            r_red_cnt <= '0;
        end else begin
            if (i_cmd.restart || i_cmd.fail || i_cmd.accept) begin
                r_sp  <= '0;
                r_top <= '0;
            end else if (i_cmd.shift) begin
                r_sp  <= r_sp + SpW'(1);
                r_top <= r_act.next;
            end else if (i_cmd.reduce_finish) begin
                r_sp  <= r_base + SpW'(1);
                r_top <= r_goto_q.target;
            end
            if (i_cmd.token_start) begin
                r_red_cnt <= '0;
            end else if (i_cmd.reduce_finish) begin
                r_red_cnt <= r_red_cnt + RcW'(1);
            end
        end
    end

    // Token column latch.
    always_ff @(posedge i_clk) begin
        if (i_cmd.token_start) begin
            r_col <= i_column;
        end
    end

    // Result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.load_action || i_cmd.load_goto || i_cmd.restart
                        || i_cmd.fail || i_cmd.shift || i_cmd.accept
                        || i_cmd.reduce_finish;
        end
    end

    // Next result payload.
    always_comb begin
        n_prod      = '0;
        n_last      = 1'b1;
        n_state_now = '0;
        n_kind      = KIND_LOAD;
        if (i_cmd.load_action || i_cmd.load_goto) begin
            n_state_now = r_top;
        end else if (i_cmd.fail) begin
            n_kind = KIND_ERROR;
        end else if (i_cmd.accept) begin
            n_kind = KIND_ACCEPT;
        end else if (i_cmd.shift) begin
            n_kind      = KIND_SHIFT;
            n_state_now = r_act.next;
        end else if (i_cmd.reduce_finish) begin
            n_kind      = KIND_REDUCE;
            n_prod      = r_act.prod;
            n_state_now = r_goto_q.target;
            n_last      = 1'b0;
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        r_prod      <= n_prod;
        r_last      <= n_last;
        r_state_now <= n_state_now;
        r_kind      <= n_kind;
    end

    assign o_strobe     = r_strobe;
    assign o_kind       = r_kind;
    assign o_production = r_prod;
    assign o_state_now  = r_state_now;
    assign o_last       = r_last;

endmodule

[hw/rtl/lr_shift_reduce_parser_unit.sv]
// Top level of the table-driven LR shift-reduce parser unit.
//
// Usage: an input transaction is taken at a rising edge where start is high and
// busy is low. The opcode selects an ACTION load, a GOTO load, a token (already
// mapped to its terminal column) or a restart of the parse.
// Results leave on the o_ ports for exactly one cycle each, marked by o_strobe;
// the receiver cannot stall them. o_last marks the final result of a transaction.
// Loads and restart: one result in the cycle after acceptance; busy stays low,
// so one such transaction can be taken every cycle.
// Token: the ACTION read is issued at acceptance and decoded in the next cycle,
// and a shift, accept or error result is registered from that decode. Each
// completed reduction before it passes through ACTION decode, state stack read
// and GOTO read, in series; a token makes at most MAX_REDUCTIONS reductions.
// A failing GOTO lookup gives its error result after the GOTO read, and a column
// outside the table gives its error in the cycle after acceptance. The next
// transaction is taken as the final result shows.
// Reset (synchronous, active low) empties the stack to state 0 and then runs a
// clearing pass over the NUM_STATES * NUM_NONTERMINALS GOTO entries (512 by
// default), with busy high. ACTION entries hold nothing until loaded.
module lr_shift_reduce_parser_unit import lrp_pkg::*; #(
    parameter int NUM_STATES       = DEF_NUM_STATES,
    parameter int NUM_TERMINALS    = DEF_NUM_TERMINALS,
    parameter int NUM_NONTERMINALS = DEF_NUM_NONTERMINALS,
    parameter int STACK_DEPTH      = DEF_STACK_DEPTH,
    parameter int MAX_REDUCTIONS   = DEF_MAX_REDUCTIONS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [STATE_W-1:0]  i_state_index,
    input  logic [COLUMN_W-1:0] i_column,
    input  logic [MODE_W-1:0]   i_entry_mode,
    input  logic [STATE_W-1:0]  i_entry_state,
    input  logic [LEN_W-1:0]    i_rhs_length,
    input  logic [COLUMN_W-1:0] i_lhs_symbol,
    input  logic [PROD_W-1:0]   i_production_number,
    output logic                o_strobe,
    output logic [KIND_W-1:0]   o_kind,
    output logic [PROD_W-1:0]   o_production,
    output logic [STATE_W-1:0]  o_state_now,
    output logic                o_last
);

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer.
    lrp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    // Tables, stack and result register.
    lrp_dpath #(
        .NUM_STATES       (NUM_STATES),
        .NUM_TERMINALS    (NUM_TERMINALS),
        .NUM_NONTERMINALS (NUM_NONTERMINALS),
        .STACK_DEPTH      (STACK_DEPTH),
        .MAX_REDUCTIONS   (MAX_REDUCTIONS)
    ) u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .i_state_index       (i_state_index),
        .i_column            (i_column),
        .i_entry_mode        (i_entry_mode),
        .i_entry_state       (i_entry_state),
        .i_rhs_length        (i_rhs_length),
        .i_lhs_symbol        (i_lhs_symbol),
        .i_production_number (i_production_number),
        .o_strobe            (o_strobe),
        .o_kind              (o_kind),
        .o_production        (o_production),
        .o_state_now         (o_state_now),
        .o_last              (o_last)
    );

endmodule

[hw/rtl/lrp_checker.sv]
// Port-level assertion checker for the LR shift-reduce parser unit, with its bind.
module lrp_checker import lrp_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic [OPCODE_W-1:0] i_opcode,
    input logic                o_strobe,
    input logic [KIND_W-1:0]   o_kind,
    input logic [PROD_W-1:0]   o_production,
    input logic [STATE_W-1:0]  o_state_now,
    input logic                o_last
);

    // Reset is followed by the GOTO clearing pass, so no transaction is taken.
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

    // Only a reduce result can be followed by more results of the same transaction.
    a_not_last_is_reduce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> o_kind == KIND_REDUCE)
        else $error("non-final result that is not a reduce");

    // Production number is reported only on reduce results.
    a_prod_only_reduce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_kind != KIND_REDUCE |-> o_production == '0)
        else $error("production number on a non-reduce result");

    // Accept and error leave the stack at state 0.
    a_end_state_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_kind == KIND_ERROR || o_kind == KIND_ACCEPT)
        |-> o_state_now == '0)
        else $error("accept or error with nonzero state");

    // A load or restart transaction answers with one load-done result next cycle.
    a_load_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_opcode != OP_TOKEN
        |=> o_strobe && o_last && o_kind == KIND_LOAD)
        else $error("load transaction without its load-done result");

endmodule

bind lr_shift_reduce_parser_unit lrp_checker u_lrp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_opcode     (i_opcode),
    .o_strobe     (o_strobe),
    .o_kind       (o_kind),
    .o_production (o_production),
    .o_state_now  (o_state_now),
    .o_last       (o_last)
);

[tb/sv/lr_parse_result_checker.sv]
// Result checker for the LR parser unit: predicts every result and compares it.
module lr_parse_result_checker import lrp_pkg::*; #(
    parameter int NUM_STATES       = DEF_NUM_STATES,
    parameter int NUM_TERMINALS    = DEF_NUM_TERMINALS,
    parameter int NUM_NONTERMINALS = DEF_NUM_NONTERMINALS,
    parameter int STACK_DEPTH      = DEF_STACK_DEPTH,
    parameter int MAX_REDUCTIONS   = DEF_MAX_REDUCTIONS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [STATE_W-1:0]  i_state_index,
    input  logic [COLUMN_W-1:0] i_column,
    input  logic [MODE_W-1:0]   i_entry_mode,
    input  logic [STATE_W-1:0]  i_entry_state,
    input  logic [LEN_W-1:0]    i_rhs_length,
    input  logic [COLUMN_W-1:0] i_lhs_symbol,
    input  logic [PROD_W-1:0]   i_production_number,
    input  logic                i_res_strobe,
    input  logic [KIND_W-1:0]   i_res_kind,
    input  logic [PROD_W-1:0]   i_res_production,
    input  logic [STATE_W-1:0]  i_res_state_now,
    input  logic                i_res_last,
    output int                  o_mismatch_count,
    output int                  o_results_pending,
    output int                  o_transaction_count,
    output int                  o_reduce_count,
    output int                  o_accept_count,
    output int                  o_error_count,
    output int                  o_peak_depth
);
    timeunit 1ns;
    timeprecision 1ps;

    // One result transaction as it leaves the block.
    typedef struct packed {
        t_kind              kind;
        logic [PROD_W-1:0]  production;
        logic [STATE_W-1:0] state_now;
        logic               last;
    } t_parse_result;

    // Shadow copy of the tables and the parse stack.
    t_act_entry         action_rows [NUM_STATES*NUM_TERMINALS];
    t_goto_entry        goto_rows   [NUM_STATES*NUM_NONTERMINALS];
    logic [STATE_W-1:0] parse_stack [STACK_DEPTH];
    int                 stack_top;

    t_parse_result expected_results[$];

    int mismatches      = 0;
    int results_waiting = 0;
    int transactions    = 0;
    int reductions_seen = 0;
    int accepts_seen    = 0;
    int errors_seen     = 0;
    int peak_depth      = 1;

    assign o_mismatch_count    = mismatches;
    assign o_results_pending   = results_waiting;
    assign o_transaction_count = transactions;
    assign o_reduce_count      = reductions_seen;
    assign o_accept_count      = accepts_seen;
    assign o_error_count       = errors_seen;
    assign o_peak_depth        = peak_depth;

    // The parse returns to the single bottom state 0.
    task automatic clear_stack();
        stack_top      = 0;
        parse_stack[0] = '0;
    endtask

    // Queue one expected result and keep the coverage tallies.
    task automatic emit(input t_kind kind, input logic [PROD_W-1:0] prod,
                        input logic [STATE_W-1:0] state_now, input logic last);
        expected_results.insert(expected_results.size(),
                                t_parse_result'{kind: kind, production: prod,
                                                state_now: state_now, last: last});
        case (kind)
            KIND_REDUCE: reductions_seen++;
            KIND_ACCEPT: accepts_seen++;
            KIND_ERROR:  errors_seen++;
            default: ;
        endcase
        if (stack_top + 1 > peak_depth) begin
            peak_depth = stack_top + 1;
        end
    endtask

    // An error ends the token and empties the stack.
    task automatic abort_parse();
        clear_stack();
        emit(KIND_ERROR, '0, '0, 1'b1);
    endtask

    // Work out every result that one accepted transaction causes.
    task automatic predict_transaction(input t_opcode op, input logic [STATE_W-1:0] row,
                                       input logic [COLUMN_W-1:0] col,
                                       input logic [MODE_W-1:0] mode,
                                       input logic [STATE_W-1:0] target,
                                       input logic [LEN_W-1:0] len,
                                       input logic [COLUMN_W-1:0] lhs,
                                       input logic [PROD_W-1:0] prod);
        t_act_entry  act;
        t_goto_entry jump;
        int          reductions;
        int          base;
        bit          ended;
        bit          bad;
        reductions = 0;
        ended      = 1'b0;
        base       = 0;
        case (op)
            OP_LOAD_ACTION: begin
                if (row < NUM_STATES && col < NUM_TERMINALS) begin
                    action_rows[row * NUM_TERMINALS + col] =
                        '{mode: t_act_mode'(mode), next: target, len: len, lhs: lhs, prod: prod};
                end
                emit(KIND_LOAD, '0, parse_stack[stack_top], 1'b1);
            end
            OP_LOAD_GOTO: begin
                if (row < NUM_STATES && col < NUM_NONTERMINALS) begin
                    goto_rows[row * NUM_NONTERMINALS + col] =
                        '{valid: (mode != '0), target: target};
                end
                emit(KIND_LOAD, '0, parse_stack[stack_top], 1'b1);
            end
            OP_RESTART: begin
                clear_stack();
                emit(KIND_LOAD, '0, '0, 1'b1);
            end
            OP_TOKEN: begin
                if (col >= NUM_TERMINALS) begin
                    abort_parse();
                    ended = 1'b1;
                end
                // Reductions repeat on the same column until a shift, accept or error.
                while (!ended) begin
                    act   = action_rows[parse_stack[stack_top] * NUM_TERMINALS + col];
                    ended = 1'b1;
                    case (act.mode)
                        MODE_SHIFT: begin
                            if (act.next >= NUM_STATES || stack_top + 1 >= STACK_DEPTH) begin
                                abort_parse();
                            end else begin
                                stack_top++;
                                parse_stack[stack_top] = act.next;
                                emit(KIND_SHIFT, '0, act.next, 1'b1);
                            end
                        end
                        MODE_REDUCE: begin
                            bad = reductions >= MAX_REDUCTIONS || act.len > stack_top ||
                                  act.lhs >= NUM_NONTERMINALS;
                            if (!bad) begin
                                base = stack_top - act.len;
                                jump = goto_rows[parse_stack[base] * NUM_NONTERMINALS + act.lhs];
                                bad  = !jump.valid || jump.target >= NUM_STATES ||
                                       base + 1 >= STACK_DEPTH;
                            end
                            if (bad) begin
                                abort_parse();
                            end else begin
                                stack_top              = base + 1;
                                parse_stack[stack_top] = jump.target;
                                reductions++;
                                emit(KIND_REDUCE, act.prod, jump.target, 1'b0);
                                ended = 1'b0;
                            end
                        end
                        MODE_ACCEPT: begin
                            clear_stack();
                            emit(KIND_ACCEPT, '0, '0, 1'b1);
                        end
                        default: begin
                            abort_parse();
                        end
                    endcase
                end
            end
        endcase
    endtask

    // Count a mismatch; only the first ten are printed in full.
    task automatic note_mismatch(input string what, input t_parse_result want,
                                 input t_parse_result seen);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected kind %0d prod %0d state %0d last %0d,",
                     $time, what, want.kind, want.production, want.state_now, want.last);
            $display("    got kind %0d prod %0d state %0d last %0d",
                     seen.kind, seen.production, seen.state_now, seen.last);
        end
    endtask

    // Results are compared before a new transaction at the same edge is predicted,
    // since no result leaves in the cycle its transaction is taken.
    always @(posedge i_clk) begin : watch_channels
        t_parse_result seen;
        t_parse_result want;
        if (!i_rst_n) begin
            expected_results.delete();
            clear_stack();
            foreach (goto_rows[i]) begin
                goto_rows[i] = '0;
            end
        end else begin
            if (i_res_strobe) begin
                seen = '{kind: t_kind'(i_res_kind), production: i_res_production,
                         state_now: i_res_state_now, last: i_res_last};
                if (expected_results.size() == 0) begin
                    note_mismatch("result with nothing expected", '0, seen);
                end else begin
                    want = expected_results.pop_front();
                    if (seen !== want) begin
                        note_mismatch("result mismatch", want, seen);
                    end
                end
            end
            if (i_start && !i_busy) begin
                transactions++;
                predict_transaction(t_opcode'(i_opcode), i_state_index, i_column,
                                    i_entry_mode, i_entry_state, i_rhs_length,
                                    i_lhs_symbol, i_production_number);
            end
        end
        results_waiting <= expected_results.size();
    end

endmodule

[tb/sv/lr_shift_reduce_parser_unit_tb.sv]
// Testbench top for the LR shift-reduce parser unit: stimulus, clock, reset and verdict.
module lr_shift_reduce_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lrp_pkg::*;

    // GOTO entry modes: zero is invalid, any other value is valid.
    localparam logic [MODE_W-1:0] GOTO_INVALID    = 2'd0;
    localparam logic [MODE_W-1:0] GOTO_VALID      = 2'd1;
    localparam logic [MODE_W-1:0] GOTO_VALID_WIDE = 2'd2;
    localparam logic [MODE_W-1:0] GOTO_VALID_ALL  = 2'd3;

    // Random parses stay inside a corner of the tables that is loaded in full.
    localparam int USED_STATES  = 8;
    localparam int USED_COLUMNS = 8;
    localparam int RANDOM_ITEMS = 320;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    logic                busy;
    logic [OPCODE_W-1:0] i_opcode            = '0;
    logic [STATE_W-1:0]  i_state_index       = '0;
    logic [COLUMN_W-1:0] i_column            = '0;
    logic [MODE_W-1:0]   i_entry_mode        = '0;
    logic [STATE_W-1:0]  i_entry_state       = '0;
    logic [LEN_W-1:0]    i_rhs_length        = '0;
    logic [COLUMN_W-1:0] i_lhs_symbol        = '0;
    logic [PROD_W-1:0]   i_production_number = '0;
    logic                o_strobe;
    logic [KIND_W-1:0]   o_kind;
    logic [PROD_W-1:0]   o_production;
    logic [STATE_W-1:0]  o_state_now;
    logic                o_last;

    int mismatch_count;
    int results_pending;
    int transaction_count;
    int reduce_count;
    int accept_count;
    int error_count;
    int peak_depth;

    bit idle_enabled = 1'b1;
    int sent_count   = 0;

    lr_shift_reduce_parser_unit u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_opcode            (i_opcode),
        .i_state_index       (i_state_index),
        .i_column            (i_column),
        .i_entry_mode        (i_entry_mode),
        .i_entry_state       (i_entry_state),
        .i_rhs_length        (i_rhs_length),
        .i_lhs_symbol        (i_lhs_symbol),
        .i_production_number (i_production_number),
        .o_strobe            (o_strobe),
        .o_kind              (o_kind),
        .o_production        (o_production),
        .o_state_now         (o_state_now),
        .o_last              (o_last)
    );

    lr_parse_result_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (start),
        .i_busy              (busy),
        .i_opcode            (i_opcode),
        .i_state_index       (i_state_index),
        .i_column            (i_column),
        .i_entry_mode        (i_entry_mode),
        .i_entry_state       (i_entry_state),
        .i_rhs_length        (i_rhs_length),
        .i_lhs_symbol        (i_lhs_symbol),
        .i_production_number (i_production_number),
        .i_res_strobe        (o_strobe),
        .i_res_kind          (o_kind),
        .i_res_production    (o_production),
        .i_res_state_now     (o_state_now),
        .i_res_last          (o_last),
        .o_mismatch_count    (mismatch_count),
        .o_results_pending   (results_pending),
        .o_transaction_count (transaction_count),
        .o_reduce_count      (reduce_count),
        .o_accept_count      (accept_count),
        .o_error_count       (error_count),
        .o_peak_depth        (peak_depth)
    );

    // 4 ns clock.
    always #2 i_clk = ~i_clk;

    // Random picks inside the loaded corner of the tables.
    function automatic logic [STATE_W-1:0] rand_state();
        return STATE_W'($urandom_range(USED_STATES - 1));
    endfunction

    function automatic logic [COLUMN_W-1:0] rand_column();
        return COLUMN_W'($urandom_range(USED_COLUMNS - 1));
    endfunction

    // Present one transaction and hold it until the block takes it. Start stays
    // high afterwards so that back-to-back transactions need no extra edge.
    task automatic send_cmd(input t_opcode op, input logic [STATE_W-1:0] row,
                            input logic [COLUMN_W-1:0] col, input logic [MODE_W-1:0] mode,
                            input logic [STATE_W-1:0] target, input logic [LEN_W-1:0] len,
                            input logic [COLUMN_W-1:0] lhs, input logic [PROD_W-1:0] prod);
        while (idle_enabled && $urandom_range(99) < 14) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start               <= 1'b1;
        i_opcode            <= op;
        i_state_index       <= row;
        i_column            <= col;
        i_entry_mode        <= mode;
        i_entry_state       <= target;
        i_rhs_length        <= len;
        i_lhs_symbol        <= lhs;
        i_production_number <= prod;
        do @(posedge i_clk); while (busy);
        sent_count++;
    endtask

    task automatic load_action(input logic [STATE_W-1:0] row, input logic [COLUMN_W-1:0] col,
                               input t_act_mode mode, input logic [STATE_W-1:0] next,
                               input logic [LEN_W-1:0] len, input logic [COLUMN_W-1:0] lhs,
                               input logic [PROD_W-1:0] prod);
        send_cmd(OP_LOAD_ACTION, row, col, mode, next, len, lhs, prod);
    endtask

    // Fields that a GOTO load does not use carry random values.
    task automatic load_goto(input logic [STATE_W-1:0] row, input logic [COLUMN_W-1:0] col,
                             input logic [MODE_W-1:0] mode, input logic [STATE_W-1:0] target);
        send_cmd(OP_LOAD_GOTO, row, col, mode, target, LEN_W'($urandom()),
                 COLUMN_W'($urandom()), PROD_W'($urandom()));
    endtask

    task automatic send_token(input logic [COLUMN_W-1:0] col);
        send_cmd(OP_TOKEN, STATE_W'($urandom()), col, MODE_W'($urandom()),
                 STATE_W'($urandom()), LEN_W'($urandom()), COLUMN_W'($urandom()),
                 PROD_W'($urandom()));
    endtask

    task automatic restart_parse();
        send_cmd(OP_RESTART, STATE_W'($urandom()), COLUMN_W'($urandom()),
                 MODE_W'($urandom()), STATE_W'($urandom()), LEN_W'($urandom()),
                 COLUMN_W'($urandom()), PROD_W'($urandom()));
    endtask

    // Entries biased toward shifts and short reductions so that parses run deep.
    task automatic load_random_action(input logic [STATE_W-1:0] row,
                                      input logic [COLUMN_W-1:0] col);
        int        pick;
        t_act_mode mode;
        pick = $urandom_range(99);
        mode = (pick < 40) ? MODE_SHIFT : (pick < 75) ? MODE_REDUCE :
               (pick < 85) ? MODE_ACCEPT : MODE_ERROR;
        load_action(row, col, mode, rand_state(),
                    LEN_W'(($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(2)),
                    rand_column(), PROD_W'($urandom()));
    endtask

    task automatic load_random_goto(input logic [STATE_W-1:0] row,
                                    input logic [COLUMN_W-1:0] col);
        load_goto(row, col,
                  ($urandom_range(6) == 0) ? GOTO_INVALID :
                  MODE_W'($urandom_range(GOTO_VALID, GOTO_VALID_ALL)),
                  rand_state());
    endtask

    // Stop sending until every expected result has come back.
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
    endtask

    // Reset once, then directed cases, a table fill and random parses.
    initial begin
        int                  random_base;
        int                  episode;
        int                  pick;
        logic [STATE_W-1:0]  deep_state;
        logic [STATE_W-1:0]  side_state;
        logic [COLUMN_W-1:0] shift_col;
        logic [COLUMN_W-1:0] reduce_col;
        logic [COLUMN_W-1:0] deep_lhs;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: tokens only read ACTION entries loaded just before.
        // A reduce whose GOTO entry was never loaded is an error.
        load_action(0, 1, MODE_REDUCE, 0, 0, 2, 31);
        send_token(1);
        // A reduce popping more states than the stack holds is an error.
        load_action(0, 2, MODE_REDUCE, 31, 7, 15, 0);
        send_token(2);
        // An explicit error entry with every other field at its maximum.
        load_action(0, 15, MODE_ERROR, 31, 7, 15, 31);
        send_token(15);
        // Shift to the highest state, then accept.
        load_action(0, 0, MODE_SHIFT, 31, 0, 0, 0);
        load_action(31, 0, MODE_ACCEPT, 0, 0, 0, 0);
        send_token(0);
        send_token(0);
        // A reduction that leads back to itself hits the reduction limit.
        load_action(0, 3, MODE_SHIFT, 5, 0, 0, 0);
        load_action(5, 4, MODE_REDUCE, 0, 1, 3, 7);
        send_token(3);
        load_goto(0, 3, GOTO_VALID_WIDE, 5);
        send_token(4);
        // Two reductions in one token, then a shift, then a restart mid-parse.
        send_token(0);
        load_action(31, 1, MODE_REDUCE, 0, 1, 0, 16);
        load_goto(0, 0, GOTO_VALID_ALL, 10);
        load_action(10, 1, MODE_REDUCE, 0, 0, 1, 1);
        load_goto(10, 1, GOTO_VALID, 21);
        load_action(21, 1, MODE_SHIFT, 0, 0, 0, 0);
        send_token(1);
        restart_parse();
        wait_drained();

        // Fill the used corner of both tables; later targets stay inside it.
        for (int s = 0; s < USED_STATES; s++) begin
            for (int c = 0; c < USED_COLUMNS; c++) begin
                load_random_action(STATE_W'(s), COLUMN_W'(c));
                load_random_goto(STATE_W'(s), COLUMN_W'(c));
            end
        end
        wait_drained();

        // Random parses, table rewrites, restarts and deep-stack runs.
        random_base = sent_count;
        episode     = 0;
        while (sent_count - random_base < RANDOM_ITEMS) begin
            idle_enabled = !(sent_count - random_base >= 100 && sent_count - random_base < 220);
            pick = $urandom_range(99);
            if (episode == 3 || pick < 4) begin
                // Shifts, and zero-length reductions followed by a shift, until the stack overflows.
                deep_state = rand_state();
                side_state = STATE_W'((int'(deep_state) + 1 + $urandom_range(USED_STATES - 2))
                                      % USED_STATES);
                shift_col  = rand_column();
                reduce_col = COLUMN_W'((int'(shift_col) + 1 + $urandom_range(USED_COLUMNS - 2))
                                       % USED_COLUMNS);
                deep_lhs   = rand_column();
                restart_parse();
                load_action(0, shift_col, MODE_SHIFT, deep_state, 0, 0, 0);
                load_action(deep_state, shift_col, MODE_SHIFT, deep_state, 0, 0, 0);
                load_action(deep_state, reduce_col, MODE_REDUCE, 0, 0, deep_lhs,
                            PROD_W'($urandom()));
                load_goto(deep_state, deep_lhs, GOTO_VALID, side_state);
                load_action(side_state, reduce_col, MODE_SHIFT, deep_state, 0, 0, 0);
                repeat (75) begin
                    send_token(($urandom_range(99) < 15) ? reduce_col : shift_col);
                end
            end else if (pick < 10) begin
                restart_parse();
            end else if (pick < 40) begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(1) != 0) begin
                        load_random_action(rand_state(), rand_column());
                    end else begin
                        load_random_goto(rand_state(), rand_column());
                    end
                end
                repeat ($urandom_range(2, 10)) send_token(rand_column());
            end else begin
                repeat ($urandom_range(2, 10)) send_token(rand_column());
            end
            if ($urandom_range(24) == 0) begin
                wait_drained();
            end
            episode++;
        end

        // Let the last token finish its longest reduction chain.
        wait_drained();
        repeat (60) @(posedge i_clk);
        $display("Ran %0d transactions: %0d reductions, %0d accepts, %0d errors.",
                 transaction_count, reduce_count, accept_count, error_count);
        $display("Parse stack reached %0d of %0d entries.", peak_depth, DEF_STACK_DEPTH);
        if (mismatch_count == 0 && results_pending == 0) begin
            $display("[lr_shift_reduce_parser_unit] OK");
        end else begin
            $display("[lr_shift_reduce_parser_unit] ERROR");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2_000_000;
        $display("[lr_shift_reduce_parser_unit] ERROR");
        $finish;
    end

endmodule
